// File: hdl/abf_pkg.sv
// Shared constants, codes and types of the allocation bitmap block.
package abf_pkg;

  // Store geometry
  localparam int WORD_BITS = 64;
  localparam int WORDS     = 16;
  localparam int CAPACITY  = WORDS * WORD_BITS;

  // Field and register widths
  localparam int IDX_W = 10;
  localparam int OP_W  = 4;
  localparam int CFG_W = 11;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_W-1:0] BITS_IN_USE_RESET = CFG_W'(1024);

  // Derived widths
  localparam int CAP_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W   = (CAP_W > CFG_W) ? CAP_W : CFG_W;
  localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_AW  = $clog2(WORD_BITS);
  localparam int PAD_W   = 1 << BIT_AW;

  // Register index of the configuration port
  localparam int REG_BITS_IN_USE = 0;

  typedef enum logic [OP_W-1:0] {
    OP_SET       = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_TEST      = 4'd2,
    OP_FIND_CLR  = 4'd3,
    OP_FIND_SET  = 4'd4,
    OP_SET_ALL   = 4'd5,
    OP_CLR_ALL   = 4'd6,
    OP_INVERT    = 4'd7,
    OP_ALL_CLR   = 4'd8,
    OP_ALL_SET   = 4'd9
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Outcome of one word step of the scan unit
  typedef struct packed {
    logic [WORD_BITS-1:0] wdata;
    logic                 we;
    logic                 stop;
    logic                 flag;
    logic                 fail;
    logic [CNT_W-1:0]     pos;
  } scan_res_t;

endpackage

// File: hdl/allocation_bitmap_find_first.sv
// Top level of the allocation bitmap with find-first, fill and all-bits tests.
//
// The bitmap is kept in flip-flops, one word per entry, cleared at once by reset, so there is
// no clearing pass. A sequencer walks the words one per cycle through a shared word unit,
// holding at the finishing word while the output stalls. After a transfer is taken the block
// scans and then loads the result register: fill, invert, all-bits tests and unsuccessful
// finds scan every word, a successful find and set, clear or test stop at the word that
// holds the bit, and range errors and unknown ops load the result without a scan. The input
// stalls for the whole scan. A finished result waits in the output register while the next
// item is taken. bits_in_use must be written over the APB port only while the block is idle;
// the block does not enforce this. A count above the store capacity acts as the capacity.
module allocation_bitmap_find_first import abf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_bit_index,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_flag,
  output logic [IDX_W-1:0]  out_found_index,
  output logic              out_range_error,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [WORD_BITS-1:0] bitmap_r [WORDS];
  logic [CFG_W-1:0]     bits_in_use_r;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  logic [CNT_W-1:0]     idx_r;
  logic                 quick_r, quick_nxt;
  logic                 err_r, err_nxt;
  logic [WORD_AW-1:0]   w_r, w_nxt;
  logic [CNT_W-1:0]     base_r, base_nxt;
  logic                 all_ok_r, all_ok_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_flag_r;
  logic [IDX_W-1:0]     out_found_r;
  logic                 out_err_r;

  logic [CNT_W-1:0]     count;
  logic                 in_xfer;
  logic                 out_free;
  logic                 last;
  logic                 finish;
  logic                 advance;
  logic                 load_out;
  logic                 wr_en;
  logic                 reg_sel;
  logic                 cfg_wr;
  logic                 single_op;
  logic                 known_op;
  logic                 res_flag;
  logic [IDX_W-1:0]     res_found;
  scan_res_t            unit_res;

  // Effective count, clipped to the store capacity
  assign count = (CNT_W'(bits_in_use_r) > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                           : CNT_W'(bits_in_use_r);

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_AW-1:2] == (CFG_AW - 2)'(REG_BITS_IN_USE));
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? CFG_DW'(bits_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= BITS_IN_USE_RESET;
    end else if (cfg_wr) begin
      bits_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  // Shared word unit
  abf_scan_unit u_unit (
    .op    (op_r),
    .word  (bitmap_r[w_r]),
    .base  (base_r),
    .count (count),
    .idx   (idx_r),
    .res   (unit_res)
  );

  // Handshake terms
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last      = (w_r == WORD_AW'(WORDS - 1));
  assign finish    = quick_r || unit_res.stop || last;
  assign advance   = (state_r == ST_SCAN) && (!finish || out_free);
  assign load_out  = (state_r == ST_SCAN) && finish && out_free;
  assign wr_en     = advance && !quick_r && unit_res.we;

  // Classify the incoming op
  always_comb begin
    single_op = 1'b0;
    known_op  = 1'b1;
    unique case (op_t'(in_op))
      OP_SET, OP_CLEAR, OP_TEST:                      single_op = 1'b1;
      OP_FIND_CLR, OP_FIND_SET, OP_SET_ALL,
      OP_CLR_ALL, OP_INVERT, OP_ALL_CLR, OP_ALL_SET:  single_op = 1'b0;
      default:                                        known_op  = 1'b0;
    endcase
  end

  // Result of the finishing step
  always_comb begin
    res_flag  = 1'b0;
    res_found = '0;
    if (!quick_r) begin
      unique case (op_r)
        OP_TEST:                  res_flag = unit_res.flag;
        OP_FIND_CLR, OP_FIND_SET: begin
          res_flag  = unit_res.flag;
          res_found = unit_res.flag ? unit_res.pos[IDX_W-1:0] : '0;
        end
        OP_ALL_CLR, OP_ALL_SET:   res_flag = all_ok_r && !unit_res.fail;
        default:                  res_flag = 1'b0;
      endcase
    end
  end

  // Sequencer: next state and control
  always_comb begin
    state_nxt  = state_r;
    quick_nxt  = quick_r;
    err_nxt    = err_r;
    w_nxt      = w_r;
    base_nxt   = base_r;
    all_ok_nxt = all_ok_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          err_nxt    = single_op && (CNT_W'(in_bit_index) >= count);
          quick_nxt  = !known_op || (single_op && (CNT_W'(in_bit_index) >= count));
          w_nxt      = '0;
          base_nxt   = '0;
          all_ok_nxt = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end else if (advance) begin
          w_nxt      = w_r + WORD_AW'(1);
          base_nxt   = base_r + CNT_W'(WORD_BITS);
          all_ok_nxt = all_ok_r && !unit_res.fail;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: drop on transfer, load on finish
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      quick_r     <= 1'b0;
      err_r       <= 1'b0;
      w_r         <= '0;
      base_r      <= '0;
      all_ok_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      quick_r     <= quick_nxt;
      err_r       <= err_nxt;
      w_r         <= w_nxt;
      base_r      <= base_nxt;
      all_ok_r    <= all_ok_nxt;
    end
  end

  // Hold the request payload for the scan
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= op_t'(in_op);
      idx_r <= CNT_W'(in_bit_index);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_flag_r  <= res_flag;
      out_found_r <= res_found;
      out_err_r   <= quick_r && err_r;
    end
  end

  // Bitmap store, one word written per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) begin
        bitmap_r[i] <= '0;
      end
    end else if (wr_en) begin
      bitmap_r[w_r] <= unit_res.wdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_flag        = out_flag_r;
  assign out_found_index = out_found_r;
  assign out_range_error = out_err_r;

endmodule

// File: hdl/abf_scan_unit.sv
// Word step unit: masks, modifies, tests and searches one bitmap word.
module abf_scan_unit import abf_pkg::*; (
  input  op_t                  op,
  input  logic [WORD_BITS-1:0] word,
  input  logic [CNT_W-1:0]     base,
  input  logic [CNT_W-1:0]     count,
  input  logic [CNT_W-1:0]     idx,
  output scan_res_t            res
);

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  // Binary search for the lowest set bit, halving the window each step
  function automatic logic [BIT_AW-1:0] lowest_one(input logic [PAD_W-1:0] v);
    logic [PAD_W-1:0]  x;
    logic [BIT_AW-1:0] p;
    logic [PAD_W-1:0]  lo;
    int                half;
    x = v;
    p = '0;
    for (int s = BIT_AW - 1; s >= 0; s--) begin
      half = 1 << s;
      lo = (PAD_W'(1) << half) - PAD_W'(1);
      if ((x & lo) == '0) begin
        x = x >> half;
        p = p | BIT_AW'(half);
      end
    end
    return p;
  endfunction

  logic [CNT_W-1:0]     left;
  logic [WORD_BITS-1:0] mask;
  logic [CNT_W-1:0]     off;
  logic                 hit;
  logic [WORD_BITS-1:0] bitsel;
  logic [WORD_BITS-1:0] cand;

  // Valid-bit mask of this word under the in-use count
  assign left   = count - base;
  assign mask   = (base >= count) ? '0 : ~(ONES << left);

  // Single-bit position relative to this word
  assign off    = idx - base;
  assign hit    = (off < CNT_W'(WORD_BITS));
  assign bitsel = WORD_BITS'(1) << off;

  // Candidate bits for a search
  assign cand   = ((op == OP_FIND_SET) ? word : ~word) & mask;

  always_comb begin
    res       = '0;
    res.wdata = word;
    res.pos   = base + CNT_W'(lowest_one(PAD_W'(cand)));
    unique case (op)
      OP_SET: begin
        res.wdata = word | bitsel;
        res.we    = hit;
        res.stop  = hit;
      end
      OP_CLEAR: begin
        res.wdata = word & ~bitsel;
        res.we    = hit;
        res.stop  = hit;
      end
      OP_TEST: begin
        res.flag  = |(word & bitsel);
        res.stop  = hit;
      end
      OP_FIND_CLR, OP_FIND_SET: begin
        res.stop  = |cand;
        res.flag  = |cand;
      end
      OP_SET_ALL: begin
        res.wdata = ONES;
        res.we    = 1'b1;
      end
      OP_CLR_ALL: begin
        res.wdata = '0;
        res.we    = 1'b1;
      end
      OP_INVERT: begin
        res.wdata = ~word;
        res.we    = 1'b1;
      end
      OP_ALL_CLR: begin
        res.fail  = |(word & mask);
      end
      OP_ALL_SET: begin
        res.fail  = |(~word & mask);
      end
      default: begin
        res.wdata = word;
      end
    endcase
  end

endmodule

// File: hdl/abf_checker.sv
// Port-level checks of the allocation bitmap block, bound to the top level.
module abf_checker import abf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_flag,
  input logic [IDX_W-1:0] out_found_index,
  input logic             out_range_error
);

  // Block is busy in the cycle after it takes a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_flag)
      && $stable(out_found_index) && $stable(out_range_error))
    else $error("stalled result changed");

  // Range error carries no flag and no position
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> !out_flag && (out_found_index == '0))
    else $error("range error with flag or position");

  // A position is reported only with the found flag
  a_pos_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flag |-> (out_found_index == '0))
    else $error("position without flag");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind allocation_bitmap_find_first abf_checker u_abf_checker (.*);
